// ----- rtl/stsc_pkg.sv -----
// ----------------------------------------------------------------------------
// stsc_pkg: shared definitions for the sorted table search block
// Table geometry, field widths, register map and the codes used by the
// search sequencer and the result channel.
// ----------------------------------------------------------------------------
package stsc_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Internal counters: entry counts up to TABLE_DEPTH, binary iterations.
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int BCNT_W = $clog2($clog2(TABLE_DEPTH) + 2);

  // Fixed widths of the channel fields.
  localparam int IDX_W   = 4;
  localparam int KEY_W   = 64;
  localparam int LSTEP_W = 5;
  localparam int BSTEP_W = 3;
  localparam int VERD_W  = 2;
  localparam int CFG_W   = 5;

  // Configuration port.
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_ENTRIES_IN_USE = '0;
  localparam logic [CFG_W-1:0]      ENTRIES_RESET      = CFG_W'(10);

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_e;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_BINARY = 2'd0,
    VERDICT_EQUAL  = 2'd1,
    VERDICT_LINEAR = 2'd2
  } verdict_e;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  typedef struct packed {
    logic               linear_found;
    logic [IDX_W-1:0]   linear_index;
    logic [LSTEP_W-1:0] linear_steps;
    logic               binary_found;
    logic [IDX_W-1:0]   binary_index;
    logic [BSTEP_W-1:0] binary_steps;
    verdict_e           verdict;
  } result_t;

endpackage

// ----- rtl/stsc_in_if.sv -----
// ----------------------------------------------------------------------------
// stsc_in_if: request channel
// Valid/ready channel that carries table writes and search requests.
// ----------------------------------------------------------------------------
interface stsc_in_if import stsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] entry_index;
  logic [KEY_W-1:0] key_value;

  modport source (output valid, req_type, entry_index, key_value, input ready);
  modport sink   (input valid, req_type, entry_index, key_value, output ready);
endinterface

// ----- rtl/stsc_out_if.sv -----
// ----------------------------------------------------------------------------
// stsc_out_if: result channel
// Valid/ready channel that carries one search result per beat.
// ----------------------------------------------------------------------------
interface stsc_out_if import stsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               linear_found;
  logic [IDX_W-1:0]   linear_index;
  logic [LSTEP_W-1:0] linear_steps;
  logic               binary_found;
  logic [IDX_W-1:0]   binary_index;
  logic [BSTEP_W-1:0] binary_steps;
  logic [VERD_W-1:0]  verdict;

  modport source (output valid, linear_found, linear_index, linear_steps,
                  binary_found, binary_index, binary_steps, verdict,
                  input ready);
  modport sink   (input valid, linear_found, linear_index, linear_steps,
                  binary_found, binary_index, binary_steps, verdict,
                  output ready);
endinterface

// ----- rtl/stsc_ram.sv -----
// ----------------------------------------------------------------------------
// stsc_ram: generic RAM, one write port and two registered read ports
// Read data appears in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module stsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra_addr_i,
  output logic [WIDTH-1:0]                             ra_data_o,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]                             rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule

// ----- rtl/sorted_table_search_compare_top.sv -----
// ----------------------------------------------------------------------------
// sorted_table_search_compare_top: key table with linear and binary search
// Stores keys in a RAM and answers each search with both probe counts.
// ----------------------------------------------------------------------------
// A write beat stores one key and returns nothing. A search beat runs a linear
// scan on read port A and a binary search on read port B of the key RAM at the
// same time, over the first entries_in_use entries, capped at the table depth.
// The block takes the next beat only once the slower of the two searches is
// done and its result is loaded into the output register. The linear scan
// reads one entry per cycle and checks each entry once its read returns; it
// stops at the first index that holds the key, or after the last entry in use.
// Each binary probe is a RAM read followed by a compare. With no entries in
// use both searches are done at acceptance, without a read.
// The result sits in an output register, so a new beat may be accepted while
// it waits to be taken; a search that finishes while that register is still
// full waits until it is taken. Table entries read before they were written
// return undefined data.
// ----------------------------------------------------------------------------
module sorted_table_search_compare_top import stsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  stsc_in_if.sink               req_i,
  stsc_out_if.source            res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    entries_q, entries_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CNT_W-1:0]    n_q, n_d;

  // Linear scan.
  logic [CNT_W-1:0]    lin_addr_q, lin_addr_d;
  logic [CNT_W-1:0]    lin_chk_q, lin_chk_d;
  logic                lin_pend_q, lin_pend_d;
  logic                lin_done_q, lin_done_d;
  logic                lin_found_q, lin_found_d;
  logic [ADDR_W-1:0]   lin_idx_q, lin_idx_d;
  logic [CNT_W-1:0]    lin_steps_q, lin_steps_d;

  // Binary search; the upper bound is kept exclusive so it never goes negative.
  logic [CNT_W-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]    hix_q, hix_d;
  logic [CNT_W-1:0]    mid_q, mid_d;
  logic                bin_wait_q, bin_wait_d;
  logic                bin_done_q, bin_done_d;
  logic                bin_found_q, bin_found_d;
  logic [ADDR_W-1:0]   bin_idx_q, bin_idx_d;
  logic [BCNT_W-1:0]   bin_steps_q, bin_steps_d;

  result_t             res_q, res_d;
  logic                res_valid_q, res_valid_d;

  logic                in_fire;
  logic                cfg_write;
  logic [CNT_W-1:0]    n_active;
  logic                lin_issue;
  logic [CNT_W-1:0]    mid_calc;
  logic                ram_we;
  logic [KEY_BITS-1:0] ra_data;
  logic [KEY_BITS-1:0] rb_data;

  stsc_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ADDR_W'(req_i.entry_index)),
    .wdata_i   (KEY_BITS'(req_i.key_value)),
    .ra_addr_i (ADDR_W'(lin_addr_q)),
    .ra_data_o (ra_data),
    .rb_addr_i (ADDR_W'(mid_calc)),
    .rb_data_o (rb_data)
  );

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_ENTRIES_IN_USE);
  assign entries_d = cfg_write ? CFG_W'(pwdata) : entries_q;
  assign prdata    = (paddr == REG_ENTRIES_IN_USE) ? APB_DATA_W'(entries_q) : '0;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign ram_we      = in_fire && (req_type_e'(req_i.req_type) == REQ_WRITE)
                       && (32'(req_i.entry_index) < TABLE_DEPTH);

  assign n_active  = (32'(entries_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries_q);
  assign lin_issue = !lin_done_q && (lin_addr_q < n_q);
  assign mid_calc  = lo_q + ((hix_q - lo_q - CNT_W'(1)) >> 1);

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    n_d         = n_q;
    lin_addr_d  = lin_addr_q;
    lin_chk_d   = lin_chk_q;
    lin_pend_d  = lin_pend_q;
    lin_done_d  = lin_done_q;
    lin_found_d = lin_found_q;
    lin_idx_d   = lin_idx_q;
    lin_steps_d = lin_steps_q;
    lo_d        = lo_q;
    hix_d       = hix_q;
    mid_d       = mid_q;
    bin_wait_d  = bin_wait_q;
    bin_done_d  = bin_done_q;
    bin_found_d = bin_found_q;
    bin_idx_d   = bin_idx_q;
    bin_steps_d = bin_steps_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_fire && (req_type_e'(req_i.req_type) == REQ_SEARCH)) begin
          state_d     = S_RUN;
          key_d       = KEY_BITS'(req_i.key_value);
          n_d         = n_active;
          lin_addr_d  = '0;
          lin_pend_d  = 1'b0;
          lin_done_d  = (n_active == '0);
          lin_found_d = 1'b0;
          lin_idx_d   = '0;
          lin_steps_d = '0;
          lo_d        = '0;
          hix_d       = n_active;
          bin_wait_d  = 1'b0;
          bin_done_d  = (n_active == '0);
          bin_found_d = 1'b0;
          bin_idx_d   = '0;
          bin_steps_d = '0;
        end
      end
      S_RUN: begin
        // The scan issues one read per cycle and checks the entry read the
        // cycle before; a read issued alongside a hit is simply dropped.
        if (!lin_done_q) begin
          lin_pend_d = lin_issue;
          lin_chk_d  = lin_addr_q;
          if (lin_issue) begin
            lin_addr_d = lin_addr_q + CNT_W'(1);
          end
          if (lin_pend_q) begin
            lin_steps_d = lin_chk_q + CNT_W'(1);
            if (ra_data == key_q) begin
              lin_found_d = 1'b1;
              lin_idx_d   = ADDR_W'(lin_chk_q);
              lin_done_d  = 1'b1;
              lin_pend_d  = 1'b0;
            end else if (lin_chk_q == n_q - CNT_W'(1)) begin
              lin_done_d = 1'b1;
              lin_pend_d = 1'b0;
            end
          end
        end

        if (!bin_done_q) begin
          if (!bin_wait_q) begin
            if (lo_q >= hix_q) begin
              bin_done_d = 1'b1;
            end else begin
              mid_d      = mid_calc;
              bin_wait_d = 1'b1;
            end
          end else begin
            bin_wait_d  = 1'b0;
            bin_steps_d = bin_steps_q + BCNT_W'(1);
            if (rb_data == key_q) begin
              bin_found_d = 1'b1;
              bin_idx_d   = ADDR_W'(mid_q);
              bin_done_d  = 1'b1;
            end else if (rb_data < key_q) begin
              lo_d = mid_q + CNT_W'(1);
            end else begin
              hix_d = mid_q;
            end
          end
        end

        if (lin_done_q && bin_done_q && (!res_valid_q || res_o.ready)) begin
          res_d.linear_found = lin_found_q;
          res_d.linear_index = IDX_W'(lin_idx_q);
          res_d.linear_steps = LSTEP_W'(lin_steps_q);
          res_d.binary_found = bin_found_q;
          res_d.binary_index = IDX_W'(bin_idx_q);
          res_d.binary_steps = BSTEP_W'(bin_steps_q);
          if (32'(bin_steps_q) < 32'(lin_steps_q)) begin
            res_d.verdict = VERDICT_BINARY;
          end else if (32'(bin_steps_q) == 32'(lin_steps_q)) begin
            res_d.verdict = VERDICT_EQUAL;
          end else begin
            res_d.verdict = VERDICT_LINEAR;
          end
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entries_q   <= ENTRIES_RESET;
      lin_pend_q  <= 1'b0;
      lin_done_q  <= 1'b1;
      bin_wait_q  <= 1'b0;
      bin_done_q  <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      entries_q   <= entries_d;
      lin_pend_q  <= lin_pend_d;
      lin_done_q  <= lin_done_d;
      bin_wait_q  <= bin_wait_d;
      bin_done_q  <= bin_done_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    n_q         <= n_d;
    lin_addr_q  <= lin_addr_d;
    lin_chk_q   <= lin_chk_d;
    lin_found_q <= lin_found_d;
    lin_idx_q   <= lin_idx_d;
    lin_steps_q <= lin_steps_d;
    lo_q        <= lo_d;
    hix_q       <= hix_d;
    mid_q       <= mid_d;
    bin_found_q <= bin_found_d;
    bin_idx_q   <= bin_idx_d;
    bin_steps_q <= bin_steps_d;
    res_q       <= res_d;
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.linear_found = res_q.linear_found;
  assign res_o.linear_index = res_q.linear_index;
  assign res_o.linear_steps = res_q.linear_steps;
  assign res_o.binary_found = res_q.binary_found;
  assign res_o.binary_index = res_q.binary_index;
  assign res_o.binary_steps = res_q.binary_steps;
  assign res_o.verdict      = res_q.verdict;

endmodule

// ----- rtl/stsc_checker.sv -----
// ----------------------------------------------------------------------------
// stsc_checker: port-level assertions for the sorted table search block
// Checks the result channel hold rule and the consistency of each result.
// ----------------------------------------------------------------------------
module stsc_checker import stsc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic               linear_found,
  input logic [IDX_W-1:0]   linear_index,
  input logic [LSTEP_W-1:0] linear_steps,
  input logic               binary_found,
  input logic [IDX_W-1:0]   binary_index,
  input logic [BSTEP_W-1:0] binary_steps,
  input logic [VERD_W-1:0]  verdict
);

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable({linear_found, linear_index,
      linear_steps, binary_found, binary_index, binary_steps, verdict}))
    else $error("result beat changed while stalled");

  // A linear hit at index k has examined exactly k + 1 entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && linear_found |-> linear_steps == LSTEP_W'(linear_index) + LSTEP_W'(1))
    else $error("linear step count does not match the hit index");

  // Indexes of a miss read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (linear_found || linear_index == '0) && (binary_found || binary_index == '0))
    else $error("index reported for a search that missed");

  // The verdict follows from the two step counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |->
      ((verdict == VERDICT_BINARY) == (LSTEP_W'(binary_steps) < linear_steps)) &&
      ((verdict == VERDICT_EQUAL) == (LSTEP_W'(binary_steps) == linear_steps)) &&
      ((verdict == VERDICT_LINEAR) == (LSTEP_W'(binary_steps) > linear_steps)))
    else $error("verdict disagrees with the step counts");

endmodule

bind sorted_table_search_compare_top stsc_checker u_stsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (res_o.valid),
  .out_ready    (res_o.ready),
  .linear_found (res_o.linear_found),
  .linear_index (res_o.linear_index),
  .linear_steps (res_o.linear_steps),
  .binary_found (res_o.binary_found),
  .binary_index (res_o.binary_index),
  .binary_steps (res_o.binary_steps),
  .verdict      (res_o.verdict)
);
